### src/gftd_pkg.sv
`timescale 1ns / 1ps
package gftd_pkg;

  localparam int TONES            = 4;
  localparam int SAMPLE_W         = 16;
  localparam int COEFF_W          = 16;
  localparam int COEFF_FRAC       = 14;
  localparam int BLEN_W           = 13;
  localparam int ENERGY_W         = 48;
  localparam int SYM_W            = 2;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 16;
  localparam int BLEN_RESET       = 256;
  localparam int DEF_STATE_WIDTH  = 40;
  localparam int DEF_ENERGY_SHIFT = 32;
  localparam int DEF_MAX_BLOCK    = 4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEFF0 = 3'd0,
    REG_COEFF1 = 3'd1,
    REG_COEFF2 = 3'd2,
    REG_COEFF3 = 3'd3,
    REG_BLEN   = 3'd4
  } cfg_reg_t;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_MAC    = 7'b0000010,
    S_UPD    = 7'b0000100,
    S_ELOAD  = 7'b0001000,
    S_EMUL   = 7'b0010000,
    S_ESTORE = 7'b0100000,
    S_COMMIT = 7'b1000000
  } state_t;

  // Energy pass: c*v1, then -(c*v1)*v2, then v1^2 and v2^2 scaled by 2^14
  typedef enum logic [1:0] {
    PH_CV1  = 2'd0,
    PH_PV2  = 2'd1,
    PH_V1SQ = 2'd2,
    PH_V2SQ = 2'd3
  } phase_t;

endpackage

### src/goertzel_four_tone_detector.sv
`timescale 1ns / 1ps
// Four-tone Goertzel detector. Each accepted sample updates four resonators
// (v = floor(coeff*v1/2^14) - v2 + x, saturated to STATE_WIDTH bits) with one
// shift-and-add multiplier per tone that walks the 16 coefficient bits, one
// bit per cycle: ready returns only after the 16 multiply steps and one update
// step, so no new sample is taken before the last one is through.
// After block_length samples (0 acts as 1, above MAX_BLOCK acts as MAX_BLOCK)
// one shared bit-serial multiplier forms v1^2 + v2^2 - coeff*v1*v2 for each
// tone in turn, through the load, multiply, store and commit states, before
// the result is offered; no sample is taken during that pass.
// The result carries each energy shifted right by ENERGY_SHIFT and saturated
// to 48 bits, plus the index of the strongest tone (lowest index on ties).
// A finished result waits in the output register while the next block runs.
// Configuration writes go through cfg_wr_en/cfg_index/cfg_data and are taken
// at once; coefficients are Q2.14, samples Q1.15. Write only while idle.
module goertzel_four_tone_detector #(
  parameter int STATE_WIDTH  = gftd_pkg::DEF_STATE_WIDTH,
  parameter int ENERGY_SHIFT = gftd_pkg::DEF_ENERGY_SHIFT,
  parameter int MAX_BLOCK    = gftd_pkg::DEF_MAX_BLOCK
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_wr_en,
  input  logic [gftd_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [gftd_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [gftd_pkg::SAMPLE_W-1:0]    in_sample,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [gftd_pkg::SYM_W-1:0]              out_symbol,
  output logic [gftd_pkg::ENERGY_W-1:0]           out_energy_tone0,
  output logic [gftd_pkg::ENERGY_W-1:0]           out_energy_tone1,
  output logic [gftd_pkg::ENERGY_W-1:0]           out_energy_tone2,
  output logic [gftd_pkg::ENERGY_W-1:0]           out_energy_tone3
);
  import gftd_pkg::*;

  localparam int SW     = STATE_WIDTH;
  localparam int PW     = SW + COEFF_W;        // lane product width
  localparam int SUMW   = SW + 3;              // width of q - v2 + x
  localparam int AW     = 2 * SW + COEFF_W;    // energy accumulator width
  localparam int STEP_W = $clog2(SW);
  localparam int ESH    = COEFF_FRAC + ENERGY_SHIFT;

  // Configuration registers
  logic signed [COEFF_W-1:0] coeff_r [TONES];
  logic [BLEN_W-1:0]         blen_r;

  // Resonator state and block position
  logic signed [SW-1:0] v1_r [TONES], v1_nxt [TONES];
  logic signed [SW-1:0] v2_r [TONES], v2_nxt [TONES];
  logic [BLEN_W-1:0]    blk_cnt_r, blk_cnt_nxt;
  logic signed [SAMPLE_W-1:0] x_r, x_nxt;

  // Per-tone serial multipliers
  logic signed [PW-1:0]   lacc_r [TONES], lacc_nxt [TONES];
  logic signed [PW-1:0]   lmc_r  [TONES], lmc_nxt  [TONES];
  logic [COEFF_W-1:0]     lmp_r  [TONES], lmp_nxt  [TONES];

  // Shared energy multiplier
  logic signed [AW-1:0]   eacc_r, eacc_nxt;
  logic signed [AW-1:0]   emc_r, emc_nxt;
  logic [SW-1:0]          emp_r, emp_nxt;
  phase_t                 ph_r, ph_nxt;
  logic [SYM_W-1:0]       tone_r, tone_nxt;
  logic [AW-1:0]          best_r, best_nxt;
  logic [SYM_W-1:0]       bsym_r, bsym_nxt;
  logic [ENERGY_W-1:0]    eng_r [TONES], eng_nxt [TONES];

  state_t                 state_r, state_nxt;
  logic [STEP_W-1:0]      step_r, step_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0]       out_sym_r, out_sym_nxt;
  logic [ENERGY_W-1:0]    out_eng_r [TONES], out_eng_nxt [TONES];

  logic [BLEN_W-1:0]      len_eff;
  logic [BLEN_W-1:0]      blk_cnt_inc;
  logic                   e_last;
  logic                   e_sub;
  logic [AW-1:0]          e_sh;
  logic [ENERGY_W-1:0]    e_sat;
  logic signed [SW-1:0]   sel_v1, sel_v2;
  logic signed [PW-1:0]   lq   [TONES];
  logic signed [SUMW-1:0] lsum [TONES];

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_symbol       = out_sym_r;
  assign out_energy_tone0 = out_eng_r[0];
  assign out_energy_tone1 = out_eng_r[1];
  assign out_energy_tone2 = out_eng_r[2];
  assign out_energy_tone3 = out_eng_r[3];

  // Effective block length: zero acts as one, clamp at MAX_BLOCK
  always_comb begin
    if (blen_r == '0) begin
      len_eff = BLEN_W'(1);
    end else if (32'(blen_r) > MAX_BLOCK) begin
      len_eff = BLEN_W'(MAX_BLOCK);
    end else begin
      len_eff = blen_r;
    end
  end

  assign blk_cnt_inc = blk_cnt_r + BLEN_W'(1);
  assign sel_v1      = v1_r[tone_r];
  assign sel_v2      = v2_r[tone_r];

  // Multiplier step count: 16 for the coefficient, STATE_WIDTH otherwise
  assign e_last = (ph_r == PH_CV1) ? (step_r == STEP_W'(COEFF_W - 1))
                                   : (step_r == STEP_W'(SW - 1));
  // Sign bit of the multiplier is weighted negative; the v2 product is subtracted
  assign e_sub  = e_last ^ (ph_r == PH_PV2);

  assign e_sh  = $unsigned(eacc_r) >> ESH;
  assign e_sat = (|e_sh[AW-1:ENERGY_W]) ? {ENERGY_W{1'b1}} : e_sh[ENERGY_W-1:0];

  // Resonator update from the finished lane products
  always_comb begin
    for (int t = 0; t < TONES; t++) begin
      lq[t]   = lacc_r[t] >>> COEFF_FRAC;
      lsum[t] = lq[t][SUMW-1:0]
              - {{3{v2_r[t][SW-1]}}, v2_r[t]}
              + {{(SUMW-SAMPLE_W){x_r[SAMPLE_W-1]}}, x_r};
    end
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    x_nxt         = x_r;
    blk_cnt_nxt   = blk_cnt_r;
    eacc_nxt      = eacc_r;
    emc_nxt       = emc_r;
    emp_nxt       = emp_r;
    ph_nxt        = ph_r;
    tone_nxt      = tone_r;
    best_nxt      = best_r;
    bsym_nxt      = bsym_r;
    out_valid_nxt = out_valid_r;
    out_sym_nxt   = out_sym_r;
    for (int t = 0; t < TONES; t++) begin
      v1_nxt[t]      = v1_r[t];
      v2_nxt[t]      = v2_r[t];
      lacc_nxt[t]    = lacc_r[t];
      lmc_nxt[t]     = lmc_r[t];
      lmp_nxt[t]     = lmp_r[t];
      eng_nxt[t]     = eng_r[t];
      out_eng_nxt[t] = out_eng_r[t];
    end

    // Drop the held result once the consumer takes it
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          x_nxt    = in_sample;
          step_nxt = '0;
          for (int t = 0; t < TONES; t++) begin
            lacc_nxt[t] = '0;
            lmc_nxt[t]  = {{(PW-SW){v1_r[t][SW-1]}}, v1_r[t]};
            lmp_nxt[t]  = coeff_r[t];
          end
          state_nxt = S_MAC;
        end
      end

      S_MAC: begin
        // One coefficient bit per cycle in every lane
        for (int t = 0; t < TONES; t++) begin
          if (lmp_r[t][0]) begin
            if (step_r == STEP_W'(COEFF_W - 1)) begin
              lacc_nxt[t] = lacc_r[t] - lmc_r[t];
            end else begin
              lacc_nxt[t] = lacc_r[t] + lmc_r[t];
            end
          end
          lmc_nxt[t] = lmc_r[t] <<< 1;
          lmp_nxt[t] = lmp_r[t] >> 1;
        end
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(COEFF_W - 1)) begin
          state_nxt = S_UPD;
        end
      end

      S_UPD: begin
        for (int t = 0; t < TONES; t++) begin
          v2_nxt[t] = v1_r[t];
          if (lsum[t][SUMW-1:SW-1] != {4{lsum[t][SUMW-1]}}) begin
            v1_nxt[t] = lsum[t][SUMW-1] ? {1'b1, {(SW-1){1'b0}}}
                                        : {1'b0, {(SW-1){1'b1}}};
          end else begin
            v1_nxt[t] = lsum[t][SW-1:0];
          end
        end
        blk_cnt_nxt = blk_cnt_inc;
        if (blk_cnt_inc >= len_eff) begin
          tone_nxt  = '0;
          ph_nxt    = PH_CV1;
          state_nxt = S_ELOAD;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_ELOAD: begin
        step_nxt = '0;
        case (ph_r)
          PH_CV1: begin
            eacc_nxt = '0;
            emc_nxt  = {{(AW-SW){sel_v1[SW-1]}}, sel_v1};
            emp_nxt  = SW'($unsigned(coeff_r[tone_r]));
          end
          PH_PV2: begin
            // The coefficient product becomes the multiplicand
            eacc_nxt = '0;
            emc_nxt  = eacc_r;
            emp_nxt  = sel_v2;
          end
          PH_V1SQ: begin
            emc_nxt = {{(AW-SW){sel_v1[SW-1]}}, sel_v1} <<< COEFF_FRAC;
            emp_nxt = sel_v1;
          end
          default: begin
            emc_nxt = {{(AW-SW){sel_v2[SW-1]}}, sel_v2} <<< COEFF_FRAC;
            emp_nxt = sel_v2;
          end
        endcase
        state_nxt = S_EMUL;
      end

      S_EMUL: begin
        if (emp_r[0]) begin
          eacc_nxt = e_sub ? (eacc_r - emc_r) : (eacc_r + emc_r);
        end
        emc_nxt  = emc_r <<< 1;
        emp_nxt  = emp_r >> 1;
        step_nxt = step_r + STEP_W'(1);
        if (e_last) begin
          if (ph_r == PH_V2SQ) begin
            state_nxt = S_ESTORE;
          end else begin
            ph_nxt    = phase_t'(ph_r + 2'd1);
            state_nxt = S_ELOAD;
          end
        end
      end

      S_ESTORE: begin
        eng_nxt[tone_r] = e_sat;
        if ((tone_r == '0) || ($unsigned(eacc_r) > best_r)) begin
          best_nxt = $unsigned(eacc_r);
          bsym_nxt = tone_r;
        end
        if (tone_r == SYM_W'(TONES - 1)) begin
          state_nxt = S_COMMIT;
        end else begin
          tone_nxt  = tone_r + SYM_W'(1);
          ph_nxt    = PH_CV1;
          state_nxt = S_ELOAD;
        end
      end

      S_COMMIT: begin
        // Hold until the output register is free, then clear for the next block
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_sym_nxt   = bsym_r;
          for (int t = 0; t < TONES; t++) begin
            out_eng_nxt[t] = eng_r[t];
            v1_nxt[t]      = '0;
            v2_nxt[t]      = '0;
          end
          blk_cnt_nxt = '0;
          state_nxt   = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      blk_cnt_r   <= '0;
      blen_r      <= BLEN_W'(BLEN_RESET);
      for (int t = 0; t < TONES; t++) begin
        coeff_r[t] <= '0;
        v1_r[t]    <= '0;
        v2_r[t]    <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      blk_cnt_r   <= blk_cnt_nxt;
      for (int t = 0; t < TONES; t++) begin
        v1_r[t] <= v1_nxt[t];
        v2_r[t] <= v2_nxt[t];
      end
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_COEFF0: coeff_r[0] <= cfg_data;
          REG_COEFF1: coeff_r[1] <= cfg_data;
          REG_COEFF2: coeff_r[2] <= cfg_data;
          REG_COEFF3: coeff_r[3] <= cfg_data;
          REG_BLEN:   blen_r     <= cfg_data[BLEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    step_r    <= step_nxt;
    x_r       <= x_nxt;
    eacc_r    <= eacc_nxt;
    emc_r     <= emc_nxt;
    emp_r     <= emp_nxt;
    ph_r      <= ph_nxt;
    tone_r    <= tone_nxt;
    best_r    <= best_nxt;
    bsym_r    <= bsym_nxt;
    out_sym_r <= out_sym_nxt;
    for (int t = 0; t < TONES; t++) begin
      lacc_r[t]    <= lacc_nxt[t];
      lmc_r[t]     <= lmc_nxt[t];
      lmp_r[t]     <= lmp_nxt[t];
      eng_r[t]     <= eng_nxt[t];
      out_eng_r[t] <= out_eng_nxt[t];
    end
  end

endmodule

### dv/goertzel_four_tone_detector_test.sv
`timescale 1ns / 1ps
module goertzel_four_tone_detector_test;
  import gftd_pkg::*;

  // Resonator state range at the default width.
  localparam longint STATE_MAX = (64'sd1 <<< (DEF_STATE_WIDTH - 1)) - 1;
  localparam longint STATE_MIN = -STATE_MAX - 1;
  // Settle wait that covers an energy pass and a sample still in flight.
  localparam int SETTLE_CYCLES = 640;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int RANDOM_ITEMS  = 410;
  localparam int MAX_GAP       = 16;
  localparam int LONG_PART     = 24;
  localparam int FIFO_DEPTH    = 64;
  // First and last register index that the block does not decode.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_IDX = 3'd7;

  logic                        clk;
  logic                        rst_n;
  logic                        cfg_wr_en;
  logic [CFG_IDX_W-1:0]        cfg_index;
  logic [CFG_DATA_W-1:0]       cfg_data;
  logic                        in_valid;
  logic                        in_ready;
  logic signed [SAMPLE_W-1:0]  in_sample;
  logic                        out_valid;
  logic                        out_ready;
  logic [SYM_W-1:0]            out_symbol;
  logic [ENERGY_W-1:0]         out_energy_tone0;
  logic [ENERGY_W-1:0]         out_energy_tone1;
  logic [ENERGY_W-1:0]         out_energy_tone2;
  logic [ENERGY_W-1:0]         out_energy_tone3;

  goertzel_four_tone_detector uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_symbol       (out_symbol),
    .out_energy_tone0 (out_energy_tone0),
    .out_energy_tone1 (out_energy_tone1),
    .out_energy_tone2 (out_energy_tone2),
    .out_energy_tone3 (out_energy_tone3)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // One detection report: strongest tone and the four scaled energies.
  typedef struct packed {
    logic [SYM_W-1:0]                   sym;
    logic [TONES-1:0][ENERGY_W-1:0]     energy;
  } tone_report_t;

  // Expected reports in order of arrival.
  tone_report_t expect_fifo [FIFO_DEPTH];
  int unsigned  fifo_wr = 0;
  int unsigned  fifo_rd = 0;

  // Shadow of the detector: registers plus resonator state.
  longint      shadow_coeff[TONES];
  int unsigned shadow_blen;
  longint      shadow_v1[TONES];
  longint      shadow_v2[TONES];
  int unsigned shadow_taken;

  int errors = 0;
  int cycles = 0;

  function automatic int unsigned reports_waiting();
    return fifo_wr - fifo_rd;
  endfunction

  function automatic void report_put(tone_report_t r);
    expect_fifo[fifo_wr % FIFO_DEPTH] = r;
    fifo_wr++;
  endfunction

  function automatic tone_report_t report_take();
    tone_report_t r;
    r = expect_fifo[fifo_rd % FIFO_DEPTH];
    fifo_rd++;
    return r;
  endfunction

  function automatic void shadow_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    if (idx < TONES) begin
      shadow_coeff[idx] = longint'($signed(data));
    end else if (idx == REG_BLEN) begin
      shadow_blen = data[BLEN_W-1:0];
    end
  endfunction

  // Run one sample through the four resonators; queue a report at block end.
  function automatic void goertzel_step(logic [SAMPLE_W-1:0] x);
    longint              prod;
    longint              v;
    int unsigned         len;
    logic signed [127:0] a, b, c, e, best, s;
    tone_report_t        r;
    len = (shadow_blen == 0) ? 1 : ((shadow_blen > DEF_MAX_BLOCK) ? DEF_MAX_BLOCK : shadow_blen);
    for (int t = 0; t < TONES; t++) begin
      prod = (shadow_coeff[t] * shadow_v1[t]) >>> COEFF_FRAC;
      v = prod - shadow_v2[t] + longint'($signed(x));
      if (v > STATE_MAX) v = STATE_MAX;
      if (v < STATE_MIN) v = STATE_MIN;
      shadow_v2[t] = shadow_v1[t];
      shadow_v1[t] = v;
    end
    shadow_taken++;
    if (shadow_taken < len) return;
    r = '0;
    best = '0;
    for (int t = 0; t < TONES; t++) begin
      a = shadow_v1[t];
      b = shadow_v2[t];
      c = shadow_coeff[t];
      // Energy scaled by 2^14 keeps the cross term exact.
      e = ((a * a + b * b) <<< COEFF_FRAC) - c * a * b;
      s = e >>> (COEFF_FRAC + DEF_ENERGY_SHIFT);
      r.energy[t] = ((s >>> ENERGY_W) != 0) ? '1 : s[ENERGY_W-1:0];
      if (t == 0 || e > best) begin
        best = e;
        r.sym = t[SYM_W-1:0];
      end
    end
    report_put(r);
    for (int t = 0; t < TONES; t++) begin
      shadow_v1[t] = 0;
      shadow_v2[t] = 0;
    end
    shadow_taken = 0;
  endfunction

  // Offer one sample, hold it until the transfer, then advance the shadow.
  task automatic send_sample(logic [SAMPLE_W-1:0] x, bit eager);
    int gap;
    gap = eager ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= x;
    do @(posedge clk); while (!(in_valid && in_ready));
    goertzel_step(x);
  endtask

  // Drop valid, drain every pending report, then let any sample in flight finish.
  task automatic settle();
    in_valid <= 1'b0;
    while (reports_waiting() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Hold the write enable high across a batch; the caller lowers it afterward.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    shadow_write(idx, data);
  endtask

  // Directed rows: register writes and samples. With an effective length of
  // one every energy is x^2 >> 32, which is zero, and tone 0 wins the tie.
  typedef struct packed {
    bit                     wr;
    logic [CFG_IDX_W-1:0]   idx;
    logic [15:0]            val;
    bit                     known;
    logic [SYM_W-1:0]       exp_sym;
    logic [ENERGY_W-1:0]    exp_energy;
  } directed_row_t;

  localparam int DIRECTED_ROWS = 24;
  directed_row_t directed [DIRECTED_ROWS] = '{
    '{1'b1, REG_BLEN,   16'h0001, 1'b0, 2'd0, 48'd0},
    '{1'b1, REG_COEFF0, 16'h7FFF, 1'b0, 2'd0, 48'd0},
    '{1'b1, REG_COEFF1, 16'h8000, 1'b0, 2'd0, 48'd0},
    '{1'b1, REG_COEFF2, 16'h0000, 1'b0, 2'd0, 48'd0},
    '{1'b1, REG_COEFF3, 16'h4000, 1'b0, 2'd0, 48'd0},
    '{1'b0, REG_COEFF0, 16'h0000, 1'b1, 2'd0, 48'd0},
    '{1'b0, REG_COEFF0, 16'h7FFF, 1'b1, 2'd0, 48'd0},
    '{1'b0, REG_COEFF0, 16'h8000, 1'b1, 2'd0, 48'd0},
    '{1'b0, REG_COEFF0, 16'h0001, 1'b1, 2'd0, 48'd0},
    '{1'b0, REG_COEFF0, 16'hFFFF, 1'b1, 2'd0, 48'd0},
    '{1'b0, REG_COEFF0, 16'h5555, 1'b1, 2'd0, 48'd0},
    '{1'b0, REG_COEFF0, 16'hAAAA, 1'b1, 2'd0, 48'd0},
    // zero length acts as one; undecoded indexes are dropped
    '{1'b1, REG_BLEN,     16'h0000, 1'b0, 2'd0, 48'd0},
    '{1'b1, REG_SPARE,    16'h0000, 1'b0, 2'd0, 48'd0},
    '{1'b1, REG_LAST_IDX, 16'hFFFF, 1'b0, 2'd0, 48'd0},
    '{1'b0, REG_COEFF0, 16'h8000, 1'b1, 2'd0, 48'd0},
    // upper data bits are outside the length field: length 3
    '{1'b1, REG_BLEN,   16'hE003, 1'b0, 2'd0, 48'd0},
    '{1'b0, REG_COEFF0, 16'h7FFF, 1'b0, 2'd0, 48'd0},
    '{1'b0, REG_COEFF0, 16'h7FFF, 1'b0, 2'd0, 48'd0},
    '{1'b0, REG_COEFF0, 16'h7FFF, 1'b0, 2'd0, 48'd0},
    // length 2 with a full-swing pair
    '{1'b1, REG_BLEN,   16'h0002, 1'b0, 2'd0, 48'd0},
    '{1'b0, REG_COEFF0, 16'h7FFF, 1'b0, 2'd0, 48'd0},
    '{1'b0, REG_COEFF0, 16'h8000, 1'b0, 2'd0, 48'd0},
    '{1'b0, REG_COEFF0, 16'h1234, 1'b0, 2'd0, 48'd0}
  };

  // Result side: stall a random number of cycles per report, sometimes none.
  initial begin
    int stall;
    out_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // Compare each report transfer with the oldest expectation.
  tone_report_t                   want;
  logic [TONES-1:0][ENERGY_W-1:0] got_energy;
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got_energy = {out_energy_tone3, out_energy_tone2, out_energy_tone1, out_energy_tone0};
      if (reports_waiting() == 0) begin
        $display("%0t unexpected report: symbol %0d", $time, out_symbol);
        errors++;
      end else begin
        want = report_take();
        if (out_symbol !== want.sym) begin
          $display("%0t symbol: expected %0d actual %0d", $time, want.sym, out_symbol);
          errors++;
        end
        for (int t = 0; t < TONES; t++) begin
          if (got_energy[t] !== want.energy[t]) begin
            $display("%0t energy_tone%0d: expected %h actual %h",
                     $time, t, want.energy[t], got_energy[t]);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    bit in_cfg;
    int sent;
    int burst_len;
    bit burst;
    logic [15:0] x;
    rst_n     <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    in_sample <= '0;
    for (int t = 0; t < TONES; t++) begin
      shadow_coeff[t] = 0;
      shadow_v1[t] = 0;
      shadow_v2[t] = 0;
    end
    shadow_blen  = BLEN_RESET;
    shadow_taken = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed walk: drain before each batch of writes, then resume samples.
    in_cfg = 1'b0;
    foreach (directed[i]) begin
      if (directed[i].wr) begin
        if (!in_cfg) settle();
        in_cfg = 1'b1;
        write_reg(directed[i].idx, directed[i].val);
      end else begin
        if (in_cfg) cfg_wr_en <= 1'b0;
        in_cfg = 1'b0;
        send_sample(directed[i].val, 1'b0);
        if (directed[i].known) begin
          expect_fifo[(fifo_wr - 1) % FIFO_DEPTH] = '{directed[i].exp_sym,
                                                      {TONES{directed[i].exp_energy}}};
        end
      end
    end

    // Long block: a length above the cap acts as MAX_BLOCK. Run part of it
    // on a full-swing alternating input with tone 0 at coefficient -2, then
    // shorten the length mid-block so the block ends at the next sample.
    settle();
    write_reg(REG_BLEN, 16'h1FFF);
    write_reg(REG_COEFF0, 16'h8000);
    write_reg(REG_COEFF1, 16'h7FFF);
    write_reg(REG_COEFF3, 16'hC000);
    cfg_wr_en <= 1'b0;
    for (int i = 0; i < LONG_PART; i++) begin
      send_sample((i % 2) ? 16'h8000 : 16'h7FFF, $urandom_range(0, 7) != 0);
    end
    settle();
    write_reg(REG_BLEN, 16'h0005);
    cfg_wr_en <= 1'b0;
    send_sample(16'h7FFF, 1'b0);

    // Random phases: drain, reconfigure, stream. A partial block carries
    // over, so length changes land mid-block as well.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      for (int r = 0; r <= REG_BLEN; r++) begin
        if ($urandom_range(0, 2) == 0) begin
          if (r == REG_BLEN) begin
            case ($urandom_range(0, 9))
              0:       x = 16'h0000;
              1:       x = 16'(BLEN_RESET);
              2:       x = {3'($urandom), 13'($urandom_range(1, 12))};
              default: x = 16'($urandom_range(1, 8));
            endcase
          end else begin
            case ($urandom_range(0, 5))
              0:       x = 16'h7FFF;
              1:       x = 16'h8000;
              2:       x = 16'h0000;
              default: x = 16'($urandom);
            endcase
          end
          write_reg(3'(r), x);
        end
      end
      if ($urandom_range(0, 4) == 0) begin
        write_reg(3'($urandom_range(REG_SPARE, REG_LAST_IDX)), 16'($urandom));
      end
      cfg_wr_en <= 1'b0;
      burst_len = $urandom_range(8, 40);
      burst = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < burst_len; i++) begin
        case ($urandom_range(0, 7))
          0:       x = 16'h7FFF;
          1:       x = 16'h8000;
          default: x = 16'($urandom);
        endcase
        send_sample(x, burst);
        sent++;
      end
    end

    settle();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
src/gftd_pkg.sv
src/goertzel_four_tone_detector.sv
dv/goertzel_four_tone_detector_test.sv
